// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CPP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define CPP_ASSERT_ALWAYS(label, cond, msg) \
	`CPP_ASSERT(label, (1'b1) |-> (cond), msg)

`endif

// ===== rtl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Widths, codes and types shared by the polyline nearest-point block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

	localparam int VAL_W  = 32;  // Q16.16 coordinates and results
	localparam int DIFF_W = 33;  // exact coordinate difference
	localparam int MAG_W  = 34;  // magnitude operands of the multiplier
	localparam int OFS_W  = 35;  // offset from query to the clamped point
	localparam int WIDE_W = 68;  // products and sums of products
	localparam int QUO_W  = 35;  // quotient or root of the shift-subtract unit
	localparam int REM_W  = 37;  // partial remainder
	localparam int CNT_W  = 6;

	localparam int DIV_STEPS  = 35;
	localparam int SQRT_STEPS = 34;

	localparam logic [1:0] CFG_QUERY_X = 2'd0;
	localparam logic [1:0] CFG_QUERY_Y = 2'd1;
	localparam logic [1:0] CFG_QUERY_Z = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DOT_MUL,
		S_DOT_ACC,
		S_SEG_GO,
		S_SEG_WAIT,
		S_PROJ_DEC,
		S_PROJ_GO,
		S_PROJ_WAIT,
		S_OFF_MUL,
		S_OFF_GO,
		S_OFF_WAIT,
		S_NRM_MUL,
		S_NRM_ACC,
		S_NRM_GO,
		S_NRM_WAIT,
		S_UPDATE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} dsq_req_t;

endpackage

`default_nettype wire

// ===== rtl/cpp_divsqrt.sv =====
// ----------------------------------------------------------------------------
// cpp_divsqrt
// Shift-subtract unit: restoring division or integer square root, one result
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_divsqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cpp_pkg::dsq_req_t            req,
	input  wire logic [cpp_pkg::WIDE_W-1:0]   num,
	input  wire logic [cpp_pkg::MAG_W-1:0]    den,
	output logic                              busy,
	output logic [cpp_pkg::QUO_W-1:0]         res
);
	import cpp_pkg::*;

	localparam int T_W = REM_W + 1;

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              mode_q;
	logic [REM_W-1:0]  rem_q;
	logic [WIDE_W-1:0] sh_q;
	logic [QUO_W-1:0]  res_q;
	logic [MAG_W-1:0]  den_q;

	logic [T_W-1:0] t;
	logic [T_W-1:0] trial;
	logic [T_W-1:0] diff;
	logic           ge;

	// Division brings down one numerator bit per step, the root two.
	always_comb begin
		if (mode_q) begin
			t     = {rem_q[REM_W-2:0], sh_q[WIDE_W-1 -: 2]};
			trial = {1'b0, res_q, 2'b01};
		end else begin
			t     = {rem_q, sh_q[WIDE_W-1]};
			trial = {{(T_W-MAG_W){1'b0}}, den_q};
		end
		ge   = (t >= trial);
		diff = t - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.sqrt_mode ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.sqrt_mode;
			den_q  <= den;
			res_q  <= '0;
			if (req.sqrt_mode) begin
				rem_q <= '0;
				sh_q  <= num;
			end else begin
				// The numerator is below den * 2^35, so its top bits start below den.
				rem_q <= REM_W'(num[WIDE_W-1:DIV_STEPS]);
				sh_q  <= {num[DIV_STEPS-1:0], {(WIDE_W-DIV_STEPS){1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
			sh_q  <= mode_q ? {sh_q[WIDE_W-3:0], 2'b00} : {sh_q[WIDE_W-2:0], 1'b0};
			res_q <= {res_q[QUO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ===== rtl/closest_point_on_polyline.sv =====
// Result: valid at the end of the last vertex's work.
// Vertex flow: a vertex can be taken in the cycle after the previous one ends, not before;
// the shift-subtract unit sets the pace, one bit per cycle for up to six operations.
// Reset: asynchronous, active low; clears the query, the curve state and the sequencer.
// ----------------------------------------------------------------------------
// closest_point_on_polyline
// Nearest point on a 3-D polyline to a configured query point, Q16.16, using
// one multiplier and one iterative divide/square-root unit under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_polyline (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [cpp_pkg::VAL_W-1:0]          cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [cpp_pkg::VAL_W-1:0]   vertex_x,
	input  wire logic signed [cpp_pkg::VAL_W-1:0]   vertex_y,
	input  wire logic signed [cpp_pkg::VAL_W-1:0]   vertex_z,
	input  wire logic                               last_vertex,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [cpp_pkg::VAL_W-1:0]               arc_position,
	output logic [cpp_pkg::VAL_W-1:0]               nearest_distance
);
	import cpp_pkg::*;

	function automatic logic [MAG_W-1:0] mag(input logic signed [OFS_W-1:0] x);
		logic [OFS_W-1:0] n;
		n = x[OFS_W-1] ? OFS_W'(-x) : OFS_W'(x);
		return n[MAG_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] sat32(input logic [QUO_W-1:0] x);
		return (x[QUO_W-1:VAL_W] != '0) ? '1 : x[VAL_W-1:0];
	endfunction

	state_t state_q, state_d;

	// Control and curve state
	logic [1:0]              cnt_q;
	logic                    sel_q;
	logic                    first_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] query_q [3];
	logic signed [VAL_W-1:0] prev_q  [3];
	logic [VAL_W-1:0]        running_q;
	logic [VAL_W-1:0]        best_pos_q;
	logic [VAL_W-1:0]        best_dist_q;

	// Working registers
	logic signed [VAL_W-1:0] v_q [3];
	logic                    last_q;
	logic [WIDE_W-1:0]       prod_q;
	logic [WIDE_W-1:0]       len2_q;
	logic [WIDE_W-1:0]       pos_q;
	logic [WIDE_W-1:0]       neg_q;
	logic [WIDE_W-1:0]       acc_q;
	logic [MAG_W-1:0]        seg_q;
	logic [MAG_W-1:0]        proj_q;
	logic signed [OFS_W-1:0] e_q [3];
	logic [VAL_W-1:0]        dist_q;
	logic [VAL_W-1:0]        arc_q;
	logic [VAL_W-1:0]        near_q;

	logic signed [DIFF_W-1:0] d [3];
	logic signed [DIFF_W-1:0] w [3];
	logic signed [DIFF_W-1:0] qv [3];
	logic [MAG_W-1:0]         dmag [3];
	logic [MAG_W-1:0]         wmag [3];
	logic [MAG_W-1:0]         emag [3];
	logic signed [VAL_W-1:0]  vin [3];

	logic [MAG_W-1:0]  mul_a;
	logic [MAG_W-1:0]  mul_b;
	dsq_req_t          dsq_req;
	logic [WIDE_W-1:0] dsq_num;
	logic              dsq_busy;
	logic [QUO_W-1:0]  dsq_res;
	logic              accept;
	logic              finish_go;

	logic [WIDE_W-1:0] pn_diff;
	logic              pn_gt;
	logic              proj_sat;
	logic [QUO_W-1:0]  pos_sum;
	logic [QUO_W-1:0]  run_sum;
	logic [VAL_W-1:0]  dist_new;
	logic [DIFF_W-1:0] off;

	assign vin[0] = vertex_x;
	assign vin[1] = vertex_y;
	assign vin[2] = vertex_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]    = DIFF_W'(v_q[i]) - DIFF_W'(prev_q[i]);
			w[i]    = DIFF_W'(query_q[i]) - DIFF_W'(prev_q[i]);
			qv[i]   = DIFF_W'(query_q[i]) - DIFF_W'(vin[i]);
			dmag[i] = mag(OFS_W'(d[i]));
			wmag[i] = mag(OFS_W'(w[i]));
			emag[i] = mag(e_q[i]);
		end
	end

	assign accept    = in_valid && in_ready;
	assign pn_diff   = pos_q - neg_q;
	assign pn_gt     = pos_q > neg_q;
	// The quotient exceeds the clamp whenever it would not fit the divider.
	assign proj_sat  = {1'b0, pn_diff} >= {seg_q, {DIV_STEPS{1'b0}}};
	assign pos_sum   = QUO_W'(running_q) + QUO_W'(proj_q);
	assign run_sum   = QUO_W'(running_q) + QUO_W'(seg_q);
	assign dist_new  = sat32(dsq_res);
	assign off       = dsq_res[DIFF_W-1:0];

	cpp_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dsq_req),
		.num    (dsq_num),
		.den    (seg_q),
		.busy   (dsq_busy),
		.res    (dsq_res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = first_q ? S_NRM_MUL : S_DOT_MUL;
			end
			S_DOT_MUL: state_d = S_DOT_ACC;
			S_DOT_ACC: begin
				if (sel_q && cnt_q == 2'd2) begin
					state_d = (len2_q == '0) ? S_FINISH : S_SEG_GO;
				end else begin
					state_d = S_DOT_MUL;
				end
			end
			S_SEG_GO:  state_d = S_SEG_WAIT;
			S_SEG_WAIT: begin
				if (!dsq_busy) state_d = S_PROJ_DEC;
			end
			S_PROJ_DEC: begin
				state_d = (pn_gt && !proj_sat) ? S_PROJ_GO : S_OFF_MUL;
			end
			S_PROJ_GO: state_d = S_PROJ_WAIT;
			S_PROJ_WAIT: begin
				if (!dsq_busy) state_d = S_OFF_MUL;
			end
			S_OFF_MUL: state_d = S_OFF_GO;
			S_OFF_GO:  state_d = S_OFF_WAIT;
			S_OFF_WAIT: begin
				if (!dsq_busy) state_d = (cnt_q == 2'd2) ? S_NRM_MUL : S_OFF_MUL;
			end
			S_NRM_MUL: state_d = S_NRM_ACC;
			S_NRM_ACC: state_d = (cnt_q == 2'd2) ? S_NRM_GO : S_NRM_MUL;
			S_NRM_GO:  state_d = S_NRM_WAIT;
			S_NRM_WAIT: begin
				if (!dsq_busy) state_d = S_UPDATE;
			end
			S_UPDATE: state_d = S_FINISH;
			S_FINISH: begin
				if (finish_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: operand selection and unit launch
	always_comb begin
		mul_a             = '0;
		mul_b             = '0;
		dsq_req.start     = 1'b0;
		dsq_req.sqrt_mode = 1'b0;
		dsq_num           = '0;
		in_ready          = 1'b0;
		finish_go         = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_DOT_MUL: begin
				mul_a = dmag[cnt_q];
				mul_b = sel_q ? wmag[cnt_q] : dmag[cnt_q];
			end
			S_OFF_MUL: begin
				mul_a = proj_q;
				mul_b = dmag[cnt_q];
			end
			S_NRM_MUL: begin
				mul_a = emag[cnt_q];
				mul_b = emag[cnt_q];
			end
			S_SEG_GO: begin
				dsq_req.start     = 1'b1;
				dsq_req.sqrt_mode = 1'b1;
				dsq_num           = len2_q;
			end
			S_PROJ_GO: begin
				dsq_req.start = 1'b1;
				dsq_num       = pn_diff;
			end
			S_OFF_GO: begin
				dsq_req.start = 1'b1;
				dsq_num       = prod_q;
			end
			S_NRM_GO: begin
				dsq_req.start     = 1'b1;
				dsq_req.sqrt_mode = 1'b1;
				dsq_num           = acc_q;
			end
			S_FINISH: finish_go = !(last_q && out_valid_q && !out_ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
			running_q   <= '0;
			best_pos_q  <= '0;
			best_dist_q <= '0;
			for (int i = 0; i < 3; i++) begin
				query_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_QUERY_X: query_q[0] <= cfg_data;
					CFG_QUERY_Y: query_q[1] <= cfg_data;
					CFG_QUERY_Z: query_q[2] <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				cnt_q <= '0;
				sel_q <= 1'b0;
			end else if (state_q == S_DOT_ACC) begin
				cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				if (cnt_q == 2'd2) sel_q <= 1'b1;
			end else if ((state_q == S_OFF_WAIT && !dsq_busy) || state_q == S_NRM_ACC) begin
				cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
			end

			if (state_q == S_UPDATE) begin
				if (first_q) begin
					best_dist_q <= dist_q;
					best_pos_q  <= '0;
					running_q   <= '0;
					first_q     <= 1'b0;
				end else begin
					if (dist_q < best_dist_q) begin
						best_dist_q <= dist_q;
						best_pos_q  <= sat32(pos_sum);
					end
					running_q <= sat32(run_sum);
				end
			end

			if (finish_go) begin
				for (int i = 0; i < 3; i++) prev_q[i] <= v_q[i];
				if (last_q) first_q <= 1'b1;
			end

			if (finish_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				v_q[i] <= vin[i];
				e_q[i] <= OFS_W'(qv[i]);
			end
			last_q <= last_vertex;
			len2_q <= '0;
			pos_q  <= '0;
			neg_q  <= '0;
			acc_q  <= '0;
		end

		if (state_q == S_DOT_ACC) begin
			if (!sel_q) begin
				len2_q <= len2_q + prod_q;
			end else if (d[cnt_q][DIFF_W-1] == w[cnt_q][DIFF_W-1]) begin
				pos_q <= pos_q + prod_q;
			end else begin
				neg_q <= neg_q + prod_q;
			end
		end

		if (state_q == S_SEG_WAIT && !dsq_busy) seg_q <= dsq_res[MAG_W-1:0];

		if (state_q == S_PROJ_DEC) begin
			if (!pn_gt) proj_q <= '0;
			else if (proj_sat) proj_q <= seg_q;
		end
		if (state_q == S_PROJ_WAIT && !dsq_busy) begin
			proj_q <= (dsq_res > QUO_W'(seg_q)) ? seg_q : dsq_res[MAG_W-1:0];
		end

		// The clamped point moves from the previous vertex toward the segment's sign.
		if (state_q == S_OFF_WAIT && !dsq_busy) begin
			if (d[cnt_q][DIFF_W-1]) begin
				e_q[cnt_q] <= OFS_W'(w[cnt_q]) + OFS_W'({1'b0, off});
			end else begin
				e_q[cnt_q] <= OFS_W'(w[cnt_q]) - OFS_W'({1'b0, off});
			end
		end

		if (state_q == S_NRM_ACC) acc_q <= acc_q + prod_q;
		if (state_q == S_NRM_WAIT && !dsq_busy) dist_q <= dist_new;

		if (finish_go && last_q) begin
			arc_q  <= best_pos_q;
			near_q <= best_dist_q;
		end
	end

	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign arc_position     = arc_q;
	assign nearest_distance = near_q;

endmodule

`default_nettype wire

// ===== rtl/cpp_checker.sv =====
// ----------------------------------------------------------------------------
// cpp_checker
// Port-level checks for the polyline nearest-point block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [1:0]  cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [31:0] vertex_x,
	input wire logic [31:0] vertex_y,
	input wire logic [31:0] vertex_z,
	input wire logic        last_vertex,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] arc_position,
	input wire logic [31:0] nearest_distance
);

	logic unused_ok;
	assign unused_ok = cfg_valid ^ (|cfg_index) ^ (|cfg_data) ^ (|vertex_x) ^
		(|vertex_y) ^ (|vertex_z) ^ last_vertex;

	// A stalled result beat holds its value.
	`CPP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(arc_position) && $stable(nearest_distance), "result changed while stalled")

	// Each vertex keeps the block busy, so ready drops after a vertex beat.
	`CPP_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after a vertex beat")

	// A result is only produced while a vertex is being worked on.
	`CPP_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(!in_ready), "result appeared while idle")

	// Configuration writes are never back-pressured.
	`CPP_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind closest_point_on_polyline cpp_checker u_cpp_checker (.*);

`default_nettype wire
